>>> design/noc_injection_queue_packetizer_top_assert.svh
// ----------------------------------------------------------------------------
// NoC injection queue packetizer assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NOC_INJECTION_QUEUE_PACKETIZER_TOP_ASSERT_SVH
`define NOC_INJECTION_QUEUE_PACKETIZER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define NIQP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("niqp port check failed");

// Property checked on every clock edge, reset included.
`define NIQP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("niqp port check failed");

`endif

>>> design/niqp_pkg.sv
// ----------------------------------------------------------------------------
// niqp_pkg
// Shared types and constants of the NoC injection queue packetizer.
// ----------------------------------------------------------------------------
`default_nettype none
package niqp_pkg;

  localparam int TILE_FW   = 4;
  localparam int KIND_W    = 2;
  localparam int SIZE_W    = 13;
  localparam int ADDR_FW   = 40;
  localparam int PKT_W     = 32;
  localparam int LW_W      = 9;
  localparam int QD_W      = 4;
  localparam int INFO_W    = 32;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 152;

  localparam logic CMD_MESSAGE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic CFG_LINK_WIDTH  = 1'b0;
  localparam logic CFG_QUEUE_DEPTH = 1'b1;

  localparam logic [KIND_W-1:0] KIND_LOAD_REQ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE_REQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_RESP  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STORE_RESP = 2'd3;

  // Request to the flit count divider.
  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] bytes;
    logic [LW_W-1:0]   width;
  } div_req_t;

  // Answer from the flit count divider.
  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] flits;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/niqp_div.sv
// ----------------------------------------------------------------------------
// niqp_div
// Restoring divider that returns ceil(bytes / width), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module niqp_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  niqp_pkg::div_req_t     req,
  output niqp_pkg::div_rsp_t     rsp
);

  localparam int NUM_W = niqp_pkg::SIZE_W + 1;
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic                          busy;
  logic                          done_q;
  logic [STEP_W-1:0]             steps;
  logic [NUM_W-1:0]              num;
  logic [NUM_W-1:0]              quot;
  logic [niqp_pkg::LW_W-1:0]     rem;
  logic [niqp_pkg::LW_W-1:0]     dvs;
  logic [niqp_pkg::LW_W:0]       trial;
  logic                          fits;
  logic [niqp_pkg::LW_W-1:0]     eff_width;

  assign eff_width = (req.width == '0) ? niqp_pkg::LW_W'(1) : req.width;
  assign trial     = {rem, num[NUM_W-1]};
  assign fits      = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      steps  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
        num   <= NUM_W'(req.bytes) + NUM_W'(eff_width) - NUM_W'(1);
        dvs   <= eff_width;
        rem   <= '0;
        quot  <= '0;
      end else if (busy) begin
        rem   <= fits ? niqp_pkg::LW_W'(trial - {1'b0, dvs}) : trial[niqp_pkg::LW_W-1:0];
        quot  <= {quot[NUM_W-2:0], fits};
        num   <= {num[NUM_W-2:0], 1'b0};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done_q;
  assign rsp.flits = quot[niqp_pkg::SIZE_W-1:0];

endmodule
`default_nettype wire

>>> design/noc_injection_queue_packetizer_top.sv
// ----------------------------------------------------------------------------
// noc_injection_queue_packetizer_top
// Per-tile injection queues with a round-robin active list and packetizer.
// ----------------------------------------------------------------------------
// The slave stream carries commands: tuser selects a message (0) or a tick (1),
// and tdata carries the message fields. A message is written to its source
// tile's queue in the cycle of its transfer and answers with one result whose
// tuser bit says whether it was queued; it is loaded into the output register
// from state S_MSG. A tick serves every tile on the active list once, in list
// order, and gives one packet descriptor per served tile on the master stream,
// tlast on the final one. A tick with an empty list gives no result.
// Per served tile the sequencer steps through four states (list read, queue
// read, decode, output load); store requests and load responses also wait in
// S_TDIV for the shared restoring divider that computes the flit count, one
// quotient bit per cycle.
// The block accepts one command at a time; s_tready is low while it works.
// When the receiver stalls, the finished descriptor waits in the output
// register and the sequencer waits before loading the next one.
// Reset empties all queues and the active list, zeroes the packet counter and
// restores link_width to 32 and queue_depth to 4. Queue storage is not
// cleared; it is only read after being written. The configuration channel is
// always ready and should be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module noc_injection_queue_packetizer_top #(
  parameter int TILES       = 16,
  parameter int QUEUE_SLOTS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // src_tile, dst_tile, msg_kind, payload_bytes, requested_bytes,
  // source_address, target_address, zero fill
  input  wire logic [niqp_pkg::IN_DATA_W-1:0] s_tdata,
  // cmd
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // packet_number, from_tile, to_tile, flit_kind, flit_count, request_size,
  // from_address, to_address, zero fill
  output logic [niqp_pkg::OUT_DATA_W-1:0] m_tdata,
  // accepted
  output logic              m_tuser,
  output logic              m_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [niqp_pkg::LW_W-1:0] cfg_data
);

  localparam int TIDX_W = (TILES > 1) ? $clog2(TILES) : 1;
  localparam int TCNT_W = $clog2(TILES + 1);
  localparam int PTR_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int FILL_W = $clog2(QUEUE_SLOTS + 1);
  localparam int MEM_D  = TILES * QUEUE_SLOTS;
  localparam int MADR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MSG, S_TSTART, S_TRD, S_TMEM, S_TDIV, S_TOUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [niqp_pkg::LW_W-1:0] link_width;
  logic [niqp_pkg::QD_W-1:0] queue_depth;

  // Queue storage and per-tile queue state.
  logic [niqp_pkg::INFO_W-1:0]  info_mem [MEM_D];
  logic [niqp_pkg::ADDR_FW-1:0] from_mem [MEM_D];
  logic [niqp_pkg::ADDR_FW-1:0] to_mem   [MEM_D];
  logic [TIDX_W-1:0]            act_mem  [TILES];
  logic [PTR_W-1:0]             head_ptr [TILES];
  logic [FILL_W-1:0]            fill     [TILES];

  logic [TIDX_W-1:0]  act_head;
  logic [TCNT_W-1:0]  act_count;
  logic [TCNT_W-1:0]  remaining;
  logic [niqp_pkg::PKT_W-1:0] packet_counter;

  logic [TIDX_W-1:0]            tile;
  logic [TIDX_W-1:0]            act_q;
  logic [niqp_pkg::INFO_W-1:0]  info_q;
  logic [niqp_pkg::ADDR_FW-1:0] from_q;
  logic [niqp_pkg::ADDR_FW-1:0] to_q;
  logic [niqp_pkg::SIZE_W-1:0]  flits;
  logic [niqp_pkg::SIZE_W-1:0]  req_size;
  logic                         msg_ok;

  // Input field views.
  logic [niqp_pkg::TILE_FW-1:0] in_src;
  logic [niqp_pkg::TILE_FW-1:0] in_dst;
  logic [niqp_pkg::KIND_W-1:0]  in_kind;
  logic [niqp_pkg::SIZE_W-1:0]  in_pay;
  logic [niqp_pkg::SIZE_W-1:0]  in_req;
  logic [niqp_pkg::ADDR_FW-1:0] in_saddr;
  logic [niqp_pkg::ADDR_FW-1:0] in_taddr;

  assign in_src   = s_tdata[3:0];
  assign in_dst   = s_tdata[7:4];
  assign in_kind  = s_tdata[9:8];
  assign in_pay   = s_tdata[22:10];
  assign in_req   = s_tdata[35:23];
  assign in_saddr = s_tdata[75:36];
  assign in_taddr = s_tdata[115:76];

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic [TIDX_W-1:0] src_idx;
  logic              src_ok;
  logic [6:0]        eff_depth;
  logic              q_full;
  logic              enqueue;
  logic [PTR_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail_ptr;
  logic [MADR_W-1:0] wr_slot;
  logic [MADR_W-1:0] rd_slot;
  logic [TCNT_W:0]   list_sum;
  logic [TIDX_W-1:0] list_tail;
  logic [TIDX_W-1:0] head_next;
  logic [PTR_W-1:0]  ptr_next;
  logic [FILL_W-1:0] fill_next;
  logic [niqp_pkg::KIND_W-1:0] q_kind;

  niqp_pkg::div_req_t div_req;
  niqp_pkg::div_rsp_t div_rsp;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  // The output register takes a new result in these two states once it is free.
  assign out_load  = out_free && (state == S_MSG || state == S_TOUT);

  assign src_idx   = TIDX_W'(in_src);
  assign src_ok    = 8'(in_src) < 8'(TILES);
  assign eff_depth = (7'(queue_depth) > 7'(QUEUE_SLOTS)) ? 7'(QUEUE_SLOTS) : 7'(queue_depth);
  assign q_full    = 7'(fill[src_idx]) >= eff_depth;
  assign enqueue   = in_fire && (s_tuser == niqp_pkg::CMD_MESSAGE) && src_ok && !q_full;

  assign tail_sum = (PTR_W + 1)'(head_ptr[src_idx]) + (PTR_W + 1)'(fill[src_idx]);
  assign tail_ptr = (tail_sum >= (PTR_W + 1)'(QUEUE_SLOTS)) ?
                    PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_SLOTS)) : PTR_W'(tail_sum);
  assign wr_slot  = MADR_W'(MADR_W'(src_idx) * MADR_W'(QUEUE_SLOTS)) + MADR_W'(tail_ptr);
  assign rd_slot  = MADR_W'(MADR_W'(act_q) * MADR_W'(QUEUE_SLOTS)) + MADR_W'(head_ptr[act_q]);

  // Free position at the tail of the active list.
  assign list_sum  = (TCNT_W + 1)'(act_head) + (TCNT_W + 1)'(act_count);
  assign list_tail = (list_sum >= (TCNT_W + 1)'(TILES)) ?
                     TIDX_W'(list_sum - (TCNT_W + 1)'(TILES)) : TIDX_W'(list_sum);
  assign head_next = (act_head == TIDX_W'(TILES - 1)) ? '0 : act_head + TIDX_W'(1);
  assign ptr_next  = (head_ptr[tile] == PTR_W'(QUEUE_SLOTS - 1)) ? '0 :
                     head_ptr[tile] + PTR_W'(1);
  assign fill_next = fill[tile] - FILL_W'(1);
  assign q_kind    = info_q[5:4];

  assign div_req.start = (state == S_TMEM) &&
                         (q_kind == niqp_pkg::KIND_STORE_REQ ||
                          q_kind == niqp_pkg::KIND_LOAD_RESP);
  assign div_req.bytes = (q_kind == niqp_pkg::KIND_STORE_REQ) ? info_q[18:6] : info_q[31:19];
  assign div_req.width = link_width;

  niqp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Queue storage: written on accepted message transfers, read once per served tile.
  always_ff @(posedge clk) begin
    if (enqueue) begin
      info_mem[wr_slot] <= {in_req, in_pay, in_kind, in_dst};
      from_mem[wr_slot] <= in_saddr;
      to_mem[wr_slot]   <= in_taddr;
    end
    if (state == S_TRD) begin
      info_q <= info_mem[rd_slot];
      from_q <= from_mem[rd_slot];
      to_q   <= to_mem[rd_slot];
    end
  end

  // Active list ring: tail written by enqueue or requeue, head read per tile.
  always_ff @(posedge clk) begin
    if (enqueue && fill[src_idx] == '0) begin
      act_mem[list_tail] <= src_idx;
    end else if (state == S_TOUT && out_free && fill_next != '0) begin
      act_mem[list_tail] <= tile;
    end
    if (state == S_TSTART) begin
      act_q <= act_mem[act_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      link_width     <= niqp_pkg::LW_W'(32);
      queue_depth    <= niqp_pkg::QD_W'(4);
      act_head       <= '0;
      act_count      <= '0;
      remaining      <= '0;
      packet_counter <= '0;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < TILES; i++) begin
        head_ptr[i] <= '0;
        fill[i]     <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          niqp_pkg::CFG_LINK_WIDTH:  link_width  <= cfg_data;
          niqp_pkg::CFG_QUEUE_DEPTH: queue_depth <= cfg_data[niqp_pkg::QD_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (s_tuser == niqp_pkg::CMD_TICK) begin
              remaining <= act_count;
              state     <= S_TSTART;
            end else begin
              msg_ok <= enqueue;
              state  <= S_MSG;
              if (enqueue) begin
                fill[src_idx] <= fill[src_idx] + FILL_W'(1);
                if (fill[src_idx] == '0) begin
                  act_count <= act_count + TCNT_W'(1);
                end
              end
            end
          end
        end
        S_MSG: begin
          if (out_free) begin
            m_tuser  <= msg_ok;
            m_tlast  <= 1'b1;
            m_tdata  <= '0;
            state    <= S_IDLE;
          end
        end
        S_TSTART: begin
          if (remaining == '0) begin
            state <= S_IDLE;
          end else begin
            act_head  <= head_next;
            act_count <= act_count - TCNT_W'(1);
            state     <= S_TRD;
          end
        end
        S_TRD: begin
          tile  <= act_q;
          state <= S_TMEM;
        end
        S_TMEM: begin
          flits    <= niqp_pkg::SIZE_W'(1);
          req_size <= (q_kind == niqp_pkg::KIND_LOAD_REQ) ? info_q[31:19] :
                      niqp_pkg::SIZE_W'(1);
          state    <= div_req.start ? S_TDIV : S_TOUT;
        end
        S_TDIV: begin
          if (div_rsp.done) begin
            flits <= div_rsp.flits;
            state <= S_TOUT;
          end
        end
        S_TOUT: begin
          if (out_free) begin
            m_tuser  <= 1'b0;
            m_tlast  <= (remaining == TCNT_W'(1));
            m_tdata  <= {4'b0, to_q, from_q, req_size, flits, q_kind, info_q[3:0],
                         niqp_pkg::TILE_FW'(tile), packet_counter};
            packet_counter <= packet_counter + niqp_pkg::PKT_W'(1);
            head_ptr[tile] <= ptr_next;
            fill[tile]     <= fill_next;
            if (fill_next != '0) begin
              act_count <= act_count + TCNT_W'(1);
            end
            remaining <= remaining - TCNT_W'(1);
            state     <= (remaining == TCNT_W'(1)) ? S_IDLE : S_TSTART;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/niqp_checker.sv
// ----------------------------------------------------------------------------
// niqp_checker
// Port-level checks of the NoC injection queue packetizer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "noc_injection_queue_packetizer_top_assert.svh"
module niqp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic s_tuser,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [niqp_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic m_tuser,
  input wire logic m_tlast
);

  // A held descriptor does not change while the receiver stalls.
  `NIQP_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // Answers to queued messages are single, empty results.
  `NIQP_ASSERT(a_msg_result, m_tvalid && m_tuser |-> m_tlast && m_tdata == '0)
  // One command at a time: the block goes busy after each input transfer.
  `NIQP_ASSERT(a_busy, s_tvalid && s_tready |=> !s_tready)
  // Nothing is offered in the cycle after a reset cycle.
  `NIQP_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid)

endmodule

bind noc_injection_queue_packetizer_top niqp_checker u_niqp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

>>> tb/noc_injection_queue_packetizer_top_test.sv
// ----------------------------------------------------------------------------
// NoC injection queue packetizer testbench
// Drives message and tick commands with random gaps and receiver stalls,
// predicts every packet descriptor from a behavioral copy of the queues and
// the active list, and compares the tdata, tuser and tlast of each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class niqp_scoreboard;
  // Expected result transfers, oldest first.
  logic [niqp_pkg::OUT_DATA_W-1:0] exp_data[$];
  logic exp_user[$];
  logic exp_last[$];
  int errors;
  int results_seen;
  int packets_seen;

  // Behavioral state of the block.
  logic [8:0] link_width;
  logic [3:0] queue_depth;
  logic [3:0] q_dst[16][8];
  logic [1:0] q_kind[16][8];
  logic [12:0] q_pay[16][8];
  logic [12:0] q_req[16][8];
  logic [39:0] q_from[16][8];
  logic [39:0] q_to[16][8];
  int head_ptr[16];
  int fill[16];
  int ring[16];
  int ring_head;
  int ring_count;
  logic [31:0] pkt_counter;

  function void reset_state();
    link_width = 9'd32;
    queue_depth = 4'd4;
    foreach (head_ptr[i]) begin
      head_ptr[i] = 0;
      fill[i] = 0;
      ring[i] = 0;
    end
    ring_head = 0;
    ring_count = 0;
    pkt_counter = '0;
  endfunction

  function void write_reg(logic idx, logic [8:0] val);
    if (idx == niqp_pkg::CFG_LINK_WIDTH) link_width = val;
    else queue_depth = val[3:0];
  endfunction

  function logic [12:0] flits_for(logic [12:0] bytes, int lw);
    flits_for = 13'((int'(bytes) + lw - 1) / lw);
  endfunction

  function void push_expect(logic [niqp_pkg::OUT_DATA_W-1:0] d, logic u, logic l);
    exp_data.insert(exp_data.size(), d);
    exp_user.insert(exp_user.size(), u);
    exp_last.insert(exp_last.size(), l);
  endfunction

  // Notes one accepted command and queues the results it must produce.
  function void note_command(logic cmd, logic [niqp_pkg::IN_DATA_W-1:0] d);
    int src, depth, slot, n, lw, tile, k, idx;
    logic [1:0] kind;
    logic [12:0] cnt, rsz;
    logic [niqp_pkg::OUT_DATA_W-1:0] pd;
    if (cmd == niqp_pkg::CMD_MESSAGE) begin
      src = d[3:0];
      depth = queue_depth > 8 ? 8 : queue_depth;
      if (fill[src] >= depth) begin
        push_expect('0, 1'b0, 1'b1);
        return;
      end
      if (fill[src] == 0) begin
        ring[(ring_head + ring_count) % 16] = src;
        ring_count++;
      end
      slot = (head_ptr[src] + fill[src]) % 8;
      q_dst[src][slot] = d[7:4];
      q_kind[src][slot] = d[9:8];
      q_pay[src][slot] = d[22:10];
      q_req[src][slot] = d[35:23];
      q_from[src][slot] = d[75:36];
      q_to[src][slot] = d[115:76];
      fill[src]++;
      push_expect('0, 1'b1, 1'b1);
      return;
    end
    // A tick serves the tiles listed when it begins.
    n = ring_count;
    lw = link_width == 0 ? 1 : link_width;
    k = 0;
    for (int i = 0; i < n; i++) begin
      tile = ring[ring_head];
      ring_head = (ring_head + 1) % 16;
      ring_count--;
      slot = head_ptr[tile];
      kind = q_kind[tile][slot];
      cnt = 13'd1;
      rsz = 13'd1;
      case (kind)
        niqp_pkg::KIND_LOAD_REQ: rsz = q_req[tile][slot];
        niqp_pkg::KIND_STORE_REQ: cnt = flits_for(q_pay[tile][slot], lw);
        niqp_pkg::KIND_LOAD_RESP: cnt = flits_for(q_req[tile][slot], lw);
        default: ;
      endcase
      pd = '0;
      pd[31:0] = pkt_counter;
      pd[35:32] = tile[3:0];
      pd[39:36] = q_dst[tile][slot];
      pd[41:40] = kind;
      pd[54:42] = cnt;
      pd[67:55] = rsz;
      pd[107:68] = q_from[tile][slot];
      pd[147:108] = q_to[tile][slot];
      push_expect(pd, 1'b0, 1'b0);
      k++;
      pkt_counter++;
      head_ptr[tile] = (head_ptr[tile] + 1) % 8;
      fill[tile]--;
      if (fill[tile] != 0) begin
        ring[(ring_head + ring_count) % 16] = tile;
        ring_count++;
      end
    end
    if (k > 0) begin
      idx = exp_last.size() - 1;
      exp_last[idx] = 1'b1;
    end
  endfunction

  // Compares one result transfer with the oldest expectation.
  function void check_result(logic [niqp_pkg::OUT_DATA_W-1:0] d, logic u, logic l);
    logic [niqp_pkg::OUT_DATA_W-1:0] ed;
    logic eu, el;
    results_seen++;
    if (exp_data.size() == 0) begin
      $display("%0t: unexpected result data=%h user=%b last=%b", $time, d, u, l);
      errors++;
      return;
    end
    ed = exp_data.pop_front();
    eu = exp_user.pop_front();
    el = exp_last.pop_front();
    if (!eu) packets_seen++;
    if (d !== ed) begin
      $display("%0t: tdata mismatch expected %h actual %h", $time, ed, d);
      errors++;
    end
    if (u !== eu) begin
      $display("%0t: tuser mismatch expected %b actual %b", $time, eu, u);
      errors++;
    end
    if (l !== el) begin
      $display("%0t: tlast mismatch expected %b actual %b", $time, el, l);
      errors++;
    end
  endfunction
endclass

module noc_injection_queue_packetizer_top_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [niqp_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [niqp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [niqp_pkg::LW_W-1:0] cfg_data = '0;

  niqp_scoreboard board;
  // Chance in percent that the receiver stalls in a cycle.
  int stall_pct = 0;

  noc_injection_queue_packetizer_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Results are taken at the rising edge; m_tready is redrawn at the falling
  // edge, mostly in short bursts of stall with an occasional long one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser, m_tlast);
  end

  int stall_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: far above the slowest correct run (up to 16 packets per tick,
  // plus long receiver stalls).
  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

  // Random gap before the next command; mostly short, sometimes long.
  task automatic idle_gap();
    int n;
    if ($urandom_range(3) == 0) n = 0;
    else if ($urandom_range(9) == 0) n = $urandom_range(30, 8);
    else n = $urandom_range(3);
    repeat (n) @(negedge clk);
  endtask

  // Offers one command and holds it until the transfer completes.
  task automatic send_command(logic cmd, logic [niqp_pkg::IN_DATA_W-1:0] d);
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    board.note_command(cmd, d);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_message(int src, int dst, logic [1:0] kind, int pay, int req,
                              logic [39:0] fa, logic [39:0] ta);
    logic [niqp_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[3:0] = src[3:0];
    d[7:4] = dst[3:0];
    d[9:8] = kind;
    d[22:10] = pay[12:0];
    d[35:23] = req[12:0];
    d[75:36] = fa;
    d[115:76] = ta;
    send_command(niqp_pkg::CMD_MESSAGE, d);
  endtask

  task automatic send_tick();
    send_command(niqp_pkg::CMD_TICK, niqp_pkg::IN_DATA_W'($urandom()));
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task automatic drain();
    while (board.exp_data.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_config(logic idx, logic [niqp_pkg::LW_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int rand_size();
    int r;
    r = $urandom_range(9);
    if (r == 0) rand_size = 4096;
    else if (r == 1) rand_size = $urandom_range(8191);
    else if (r < 4) rand_size = $urandom_range(4096, 1);
    else rand_size = $urandom_range(300, 1);
  endfunction

  function automatic logic [39:0] rand_addr();
    rand_addr = 40'({$urandom(), $urandom()});
  endfunction

  // A random phase: bursts of messages then ticks, weighted toward a few
  // tiles so that queues fill up and refusals happen.
  task automatic random_phase(int items);
    int src;
    for (int i = 0; i < items; i++) begin
      idle_gap();
      if ($urandom_range(4) == 0) begin
        send_tick();
      end else begin
        src = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(15);
        send_message(src, $urandom_range(15), 2'($urandom_range(3)), rand_size(),
                     rand_size(), rand_addr(), rand_addr());
      end
    end
    // Empty the queues so the next phase starts from a known backlog.
    for (int t = 0; t < 9; t++) send_tick();
  endtask

  initial begin
    int lw_set[6];
    int qd_set[6];
    board = new();
    board.reset_state();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: extremes of every field, each message kind, an empty
    // tick, a refusal when full, and a full active list of sixteen tiles.
    send_tick();
    send_message(0, 15, niqp_pkg::KIND_LOAD_REQ, 1, 4096, '0, '1);
    send_message(15, 0, niqp_pkg::KIND_STORE_REQ, 4096, 1, '1, '0);
    send_message(15, 3, niqp_pkg::KIND_LOAD_RESP, 33, 8191, 40'h5555555555, 40'hAAAAAAAAAA);
    send_message(15, 9, niqp_pkg::KIND_STORE_RESP, 0, 0, 40'hAAAAAAAAAA, 40'h5555555555);
    send_message(15, 9, niqp_pkg::KIND_STORE_REQ, 8191, 64, '1, '1);
    send_message(15, 1, niqp_pkg::KIND_STORE_REQ, 0, 0, '0, '0);
    send_tick();
    send_tick();
    for (int t = 0; t < 16; t++)
      send_message(t, 15 - t, 2'(t), 32 * t + 1, 97 * t + 1, rand_addr(), rand_addr());
    send_tick();
    drain();

    // Phases through several register settings, extremes included.
    lw_set = '{32, 1, 256, 0, 511, 7};
    qd_set = '{4, 1, 8, 0, 15, 3};
    for (int p = 0; p < 6; p++) begin
      write_config(niqp_pkg::CFG_LINK_WIDTH, niqp_pkg::LW_W'(lw_set[p]));
      write_config(niqp_pkg::CFG_QUEUE_DEPTH, niqp_pkg::LW_W'(qd_set[p]));
      stall_pct = (p == 2) ? 0 : 25;
      random_phase(46);
      // The sender holds off until the receiver has caught up.
      drain();
    end

    $display("Covered directed corner cases and six register settings; %0d result",
             board.results_seen);
    $display("transfers checked, %0d of them packet descriptors.", board.packets_seen);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
